>>> rtl/ast_pkg.sv
package ast_pkg;

  // Token kinds as carried on the result channel
  typedef enum logic [2:0] {
    KIND_NEWLINE = 3'd0,
    KIND_END     = 3'd1,
    KIND_COMMA   = 3'd2,
    KIND_NUMBER  = 3'd3,
    KIND_IDENT   = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  // Character codes the lexer tests against
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_X_LO   = 8'h78;

  // Result record, field widths fixed by the channel
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] line_no;
    logic [15:0] start_pos;
    logic [7:0]  length;
    logic        last;
  } record_t;

  // Records produced by one accepted byte (cnt is 0, 1 or 2)
  typedef struct packed {
    logic [1:0] cnt;
    record_t    rec0;
    record_t    rec1;
  } push_t;

  // Result queue depth; a byte is taken only with room for two records
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

endpackage

>>> rtl/ast_in_if.sv
interface ast_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

>>> rtl/ast_out_if.sv
interface ast_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] line_no;
  logic [15:0] start_pos;
  logic [7:0]  length;
  logic        last;

  modport source (output valid, output kind, output line_no, output start_pos,
                  output length, output last, input ready);
  modport sink   (input valid, input kind, input line_no, input start_pos,
                  input length, input last, output ready);
endinterface

>>> rtl/ast_lex.sv
module ast_lex #(
  parameter int POSITION_WIDTH = 16,
  parameter int LINE_WIDTH     = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      ch,
  output ast_pkg::push_t  push
);

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_ZERO, M_DEC, M_HEX, M_IDENT
  } mode_t;

  mode_t                     mode_r, mode_nxt, mode_cur;
  logic [LINE_WIDTH-1:0]     line_r, line_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt, pos_inc;
  logic [POSITION_WIDTH-1:0] tstart_r, tstart_nxt;
  logic [7:0]                tlen_r, tlen_nxt;

  logic is_dec, is_alpha, is_hex, is_idc, is_x;
  logic extend, skip, have_tok, have_one;
  ast_pkg::kind_t one_kind;
  logic [7:0]     one_len;
  ast_pkg::record_t rec_tok, rec_one;

  // character classes
  always_comb begin
    is_dec   = ch inside {[8'h30:8'h39]};
    is_alpha = ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    is_hex   = is_dec || (ch inside {[8'h61:8'h66], [8'h41:8'h46]});
    is_idc   = is_dec || is_alpha || (ch == ast_pkg::CH_USCORE);
    is_x     = (ch == ast_pkg::CH_X_LO) || (ch == ast_pkg::CH_X_UP);
  end

  // saturating position step
  assign pos_inc = (pos_r == '1) ? pos_r : pos_r + 1'b1;

  // next state and records for this byte
  always_comb begin
    mode_nxt   = mode_r;
    mode_cur   = mode_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    extend     = 1'b0;
    skip       = 1'b0;
    have_tok   = 1'b0;
    have_one   = 1'b0;
    one_kind   = ast_pkg::KIND_ERROR;
    one_len    = 8'd1;

    case (mode_r)
      M_ZERO: begin
        extend = is_x || is_dec;
        if (extend) mode_nxt = is_dec ? M_DEC : M_HEX;
      end
      M_DEC:   extend = is_dec;
      M_HEX:   extend = is_hex;
      M_IDENT: extend = is_idc;
      M_COMMENT: begin
        if (ch != ast_pkg::CH_NL && ch != ast_pkg::CH_NUL) skip = 1'b1;
        else mode_cur = M_IDLE;
      end
      default: mode_cur = M_IDLE;
    endcase

    if (skip) begin
      pos_nxt = pos_inc;
    end else if (extend) begin
      if (tlen_r != 8'hFF) tlen_nxt = tlen_r + 8'd1;
      pos_nxt = pos_inc;
    end else begin
      // close a pending token, then treat the byte on its own
      have_tok = (mode_cur != M_IDLE);
      mode_nxt = M_IDLE;
      if (ch == ast_pkg::CH_SPACE || ch == ast_pkg::CH_TAB) begin
        pos_nxt = pos_inc;
      end else if (ch == ast_pkg::CH_NL) begin
        have_one = 1'b1;
        one_kind = ast_pkg::KIND_NEWLINE;
        line_nxt = (line_r == '1) ? line_r : line_r + 1'b1;
        pos_nxt  = pos_inc;
      end else if (ch == ast_pkg::CH_NUL) begin
        have_one = 1'b1;
        one_kind = ast_pkg::KIND_END;
        one_len  = 8'd0;
        line_nxt = LINE_WIDTH'(1);
        pos_nxt  = '0;
      end else if (ch == ast_pkg::CH_SEMI) begin
        mode_nxt = M_COMMENT;
        pos_nxt  = pos_inc;
      end else if (ch == ast_pkg::CH_COMMA) begin
        have_one = 1'b1;
        one_kind = ast_pkg::KIND_COMMA;
        pos_nxt  = pos_inc;
      end else if (is_idc) begin
        mode_nxt   = (ch == ast_pkg::CH_ZERO) ? M_ZERO : (is_dec ? M_DEC : M_IDENT);
        tstart_nxt = pos_r;
        tlen_nxt   = 8'd1;
        pos_nxt    = pos_inc;
      end else begin
        have_one = 1'b1;
        pos_nxt  = pos_inc;
      end
    end
  end

  // record assembly; counters cut to the channel field widths
  always_comb begin
    rec_tok.kind      = (mode_cur == M_IDENT) ? ast_pkg::KIND_IDENT : ast_pkg::KIND_NUMBER;
    rec_tok.line_no   = 16'(32'(line_r));
    rec_tok.start_pos = 16'(32'(tstart_r));
    rec_tok.length    = tlen_r;
    rec_tok.last      = !have_one;

    rec_one.kind      = one_kind;
    rec_one.line_no   = 16'(32'(line_r));
    rec_one.start_pos = 16'(32'(pos_r));
    rec_one.length    = one_len;
    rec_one.last      = 1'b1;

    push.cnt  = take ? (2'(have_tok) + 2'(have_one)) : 2'd0;
    push.rec0 = have_tok ? rec_tok : rec_one;
    push.rec1 = rec_one;
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      line_r   <= LINE_WIDTH'(1);
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= '0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
    end
  end

  // a pending token always has a non-zero length
  a_tok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_DEC || mode_r == M_HEX || mode_r == M_IDENT || mode_r == M_ZERO)
      |-> tlen_r != 8'd0)
    else $error("pending token with zero length");

  // end of input restarts line and position
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ch == ast_pkg::CH_NUL && mode_r != M_DEC && mode_r != M_HEX
     && mode_r != M_IDENT && mode_r != M_ZERO)
      |=> (pos_r == '0 && line_r == LINE_WIDTH'(1) && mode_r == M_IDLE))
    else $error("end of input did not restart counters");

endmodule

>>> rtl/ast_oq.sv
module ast_oq (
  input  logic              clk,
  input  logic              rst_n,
  input  ast_pkg::push_t    push,
  input  logic              pop,
  output ast_pkg::record_t  head,
  output logic              head_valid,
  output logic              space_ok
);

  ast_pkg::record_t             mem_r [ast_pkg::OQ_DEPTH];
  logic [ast_pkg::OQ_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [ast_pkg::OQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign wr_p1      = wr_r + 1'b1;
  assign head       = mem_r[rd_r];
  assign head_valid = (cnt_r != '0);
  // room for the two records one byte may cause
  assign space_ok   = (cnt_r <= ast_pkg::OQ_CNT_W'(ast_pkg::OQ_DEPTH - 2));

  // pointer and fill arithmetic
  always_comb begin
    wr_nxt  = wr_r + ast_pkg::OQ_PTR_W'(push.cnt);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + ast_pkg::OQ_CNT_W'(push.cnt) - ast_pkg::OQ_CNT_W'(pop);
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_r] <= push.rec0;
    if (push.cnt == 2'd2) mem_r[wr_p1] <= push.rec1;
  end

  // queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ast_pkg::OQ_CNT_W'(ast_pkg::OQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> ($past(space_ok) || space_ok) && push.cnt != 2'd3)
    else $error("push without room");

  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd0 && !pop) |=> $stable(cnt_r))
    else $error("fill count moved without traffic");

endmodule

>>> rtl/assembly_source_tokenizer_core.sv
// A record is offered from the queue head once the byte that closes it is
// taken and earlier records have left. Throughput: one byte per cycle while
// the 4-entry result queue has two free slots; one record leaves per cycle while
// out_bus.ready is high, so bytes that cause two records can stall the input.
// Reset (rst_n low, synchronous): lexer idle, line 1, position 0, queue empty.
module assembly_source_tokenizer_core #(
  parameter int POSITION_WIDTH = 16,
  parameter int LINE_WIDTH     = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  ast_in_if.sink           in_bus,
  ast_out_if.source        out_bus
);

  ast_pkg::push_t   push;
  ast_pkg::record_t head;
  logic             take, pop, head_valid, space_ok;

  // request handshakes
  assign in_bus.ready = space_ok;
  assign take         = in_bus.valid && space_ok;
  assign pop          = head_valid && out_bus.ready;

  ast_lex #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .LINE_WIDTH     (LINE_WIDTH)
  ) u_lex (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .ch    (in_bus.ch),
    .push  (push)
  );

  ast_oq u_oq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .space_ok   (space_ok)
  );

  // result channel
  assign out_bus.valid     = head_valid;
  assign out_bus.kind      = head.kind;
  assign out_bus.line_no   = head.line_no;
  assign out_bus.start_pos = head.start_pos;
  assign out_bus.length    = head.length;
  assign out_bus.last      = head.last;

endmodule
